// File: rtl/slcfd_pkg.sv
package slcfd_pkg;

  // Payload store capacity in bytes, its address width and the byte index width.
  localparam int MAX_PAYLOAD  = 64;
  localparam int ADDR_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int BYTE_INDEX_W = 6;

  // Frame descriptor queue between the parser and the drain side.
  localparam int QUEUE_DEPTH  = 2;
  localparam int QPTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL = 1'b1;

  localparam logic [7:0] SYNC_RESET = 8'hA5;
  localparam logic [7:0] TAIL_RESET = 8'h5A;

  // CRC-8 generator polynomial, MSB first.
  localparam logic [7:0] CRC_POLY = 8'h07;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_BAD_TAIL = 2'd1,
    ST_BAD_CRC  = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_TYPE,
    PH_LEN_HI,
    PH_LEN_LO,
    PH_PAYLOAD,
    PH_CRC,
    PH_TAIL
  } phase_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

  // One finished frame as seen by the drain side.
  typedef struct packed {
    status_t     status;
    logic [7:0]  ftype;
    logic [15:0] flen;
  } desc_t;

  // Payload store write port.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } mem_wr_t;

  // One byte through the CRC-8 register, bit by bit.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// File: rtl/slcfd_queue.sv
module slcfd_queue
  import slcfd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  desc_t push_data,
  output logic  full,
  input  logic  pop,
  output logic  head_valid,
  output desc_t head
);

  desc_t             entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];

  // Pointer wrap that works for any depth.
  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    if (p == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // The parser never pushes into a full queue and the drain never pops an empty one.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("descriptor pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("descriptor popped from an empty queue");

endmodule

// File: rtl/slcfd_front.sv
module slcfd_front
  import slcfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 byte_valid,
  output logic                 byte_stall,
  input  logic [7:0]           rx_byte,
  input  logic                 store_free,
  input  logic                 q_full,
  output logic                 push,
  output desc_t                push_data,
  output mem_wr_t              mem_wr
);

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  sync_value;
  logic [7:0]  tail_value;
  logic [7:0]  kept_type;
  logic [15:0] kept_length;
  logic [15:0] bytes_seen;
  logic [7:0]  running_crc;
  logic [7:0]  received_crc;
  logic        accept;
  logic [7:0]  crc_new;
  logic [15:0] seen_inc;
  status_t     check;

  assign crc_new  = crc8_step(running_crc, rx_byte);
  assign seen_inc = bytes_seen + 16'd1;

  // Payload bytes wait while the store still holds an undrained frame;
  // the tail byte waits for room in the descriptor queue.
  always_comb begin
    byte_stall = ((phase == PH_PAYLOAD) && !store_free) || ((phase == PH_TAIL) && q_full);
  end
  assign accept = byte_valid && !byte_stall;

  // Frame checks in order: tail, CRC, then length over capacity.
  always_comb begin
    priority if (rx_byte != tail_value) begin
      check = ST_BAD_TAIL;
    end else if (running_crc != received_crc) begin
      check = ST_BAD_CRC;
    end else if (kept_length > 16'(MAX_PAYLOAD)) begin
      check = ST_TOO_LONG;
    end else begin
      check = ST_GOOD;
    end
  end

  assign push             = accept && (phase == PH_TAIL);
  assign push_data.status = check;
  assign push_data.ftype  = kept_type;
  assign push_data.flen   = kept_length;

  assign mem_wr.en   = accept && (phase == PH_PAYLOAD) && (bytes_seen < 16'(MAX_PAYLOAD));
  assign mem_wr.addr = bytes_seen[ADDR_W-1:0];
  assign mem_wr.data = rx_byte;

  // Phase sequencing.
  always_comb begin
    phase_next = phase;
    if (accept) begin
      unique case (phase)
        PH_HUNT:    if (rx_byte == sync_value) phase_next = PH_TYPE;
        PH_TYPE:    phase_next = PH_LEN_HI;
        PH_LEN_HI:  phase_next = PH_LEN_LO;
        PH_LEN_LO: begin
          phase_next = ({kept_length[15:8], rx_byte} == 16'd0) ? PH_CRC : PH_PAYLOAD;
        end
        PH_PAYLOAD: if (seen_inc >= kept_length) phase_next = PH_CRC;
        PH_CRC:     phase_next = PH_TAIL;
        PH_TAIL:    phase_next = PH_HUNT;
        default:    phase_next = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HUNT;
    end else begin
      phase <= phase_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_RESET;
      tail_value <= TAIL_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYNC: sync_value <= cfg_data;
        REG_TAIL: tail_value <= cfg_data;
        default:  ;
      endcase
    end
  end

  // Header fields, byte count and CRC.
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_type    <= '0;
      kept_length  <= '0;
      bytes_seen   <= '0;
      running_crc  <= '0;
      received_crc <= '0;
    end else if (accept) begin
      unique case (phase)
        PH_TYPE:    kept_type <= rx_byte;
        PH_LEN_HI:  kept_length <= {rx_byte, 8'd0};
        PH_LEN_LO: begin
          kept_length <= {kept_length[15:8], rx_byte};
          bytes_seen  <= '0;
          running_crc <= '0;
        end
        PH_PAYLOAD: begin
          running_crc <= crc_new;
          bytes_seen  <= seen_inc;
        end
        PH_CRC:     received_crc <= rx_byte;
        default:    ;
      endcase
    end
  end

endmodule

// File: rtl/slcfd_back.sv
module slcfd_back
  import slcfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  mem_wr_t                 mem_wr,
  input  logic                    head_valid,
  input  desc_t                   head,
  output logic                    pop,
  output logic                    idle,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [1:0]              status,
  output logic [7:0]              frame_type,
  output logic [15:0]             frame_len,
  output logic                    has_data,
  output logic [7:0]              data_byte,
  output logic [BYTE_INDEX_W-1:0] byte_index,
  output logic                    last
);

  logic [7:0]        store [MAX_PAYLOAD];
  logic [7:0]        rd_data;
  back_state_t       state;
  back_state_t       state_next;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] idx_next;
  logic [ADDR_W-1:0] last_idx;
  logic [7:0]        cur_type;
  logic [15:0]       cur_len;
  logic              out_free;
  logic              start;
  logic              load;
  status_t           ld_status;
  logic [7:0]        ld_type;
  logic [15:0]       ld_len;
  logic              ld_has;
  logic [7:0]        ld_data;
  logic [ADDR_W-1:0] ld_idx;
  logic              ld_last;

  // Payload store: written by the parser, read one byte at a time here.
  always_ff @(posedge clk) begin
    if (mem_wr.en) begin
      store[mem_wr.addr] <= mem_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= store[idx];
  end

  assign out_free = !result_valid || !result_stall;
  assign idle     = (state == BK_IDLE);

  // Drain sequencer: error and empty frames give one item at once; a good
  // frame is read out byte by byte, through a fetch state and then an emit state.
  always_comb begin
    state_next = state;
    idx_next   = idx;
    pop        = 1'b0;
    start      = 1'b0;
    load       = 1'b0;
    ld_status  = ST_GOOD;
    ld_type    = cur_type;
    ld_len     = cur_len;
    ld_has     = 1'b0;
    ld_data    = '0;
    ld_idx     = '0;
    ld_last    = 1'b1;
    unique case (state)
      BK_IDLE: begin
        if (head_valid && out_free) begin
          pop = 1'b1;
          if ((head.status != ST_GOOD) || (head.flen == 16'd0)) begin
            load      = 1'b1;
            ld_status = head.status;
            ld_type   = head.ftype;
            ld_len    = head.flen;
          end else begin
            start      = 1'b1;
            idx_next   = '0;
            state_next = BK_FETCH;
          end
        end
      end
      BK_FETCH: begin
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (out_free) begin
          load    = 1'b1;
          ld_has  = 1'b1;
          ld_data = rd_data;
          ld_idx  = idx;
          ld_last = (idx == last_idx);
          if (idx == last_idx) begin
            state_next = BK_IDLE;
          end else begin
            idx_next   = idx + 1'b1;
            state_next = BK_FETCH;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (start) begin
      cur_type <= head.ftype;
      cur_len  <= head.flen;
      last_idx <= ADDR_W'(head.flen - 16'd1);
    end
  end

  // Output register; it takes a new item when the old one is gone or leaving.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status     <= ld_status;
      frame_type <= ld_type;
      frame_len  <= ld_len;
      has_data   <= ld_has;
      data_byte  <= ld_data;
      byte_index <= BYTE_INDEX_W'(ld_idx);
      last       <= ld_last;
    end
  end

  // The store is never rewritten while a frame is being read out of it.
  a_store_quiet: assert property (@(posedge clk) disable iff (rst)
    mem_wr.en |-> (state == BK_IDLE))
    else $error("payload store written during drain");

  // A fetch is always followed by its emit cycle.
  a_fetch_emit: assert property (@(posedge clk) disable iff (rst)
    (state == BK_FETCH) |=> (state == BK_EMIT))
    else $error("fetch not followed by emit");

  // Data-carrying items belong only to good frames.
  a_data_good: assert property (@(posedge clk) disable iff (rst)
    (result_valid && has_data) |-> (status == ST_GOOD))
    else $error("data item with error status");

endmodule

// File: rtl/sync_length_crc8_frame_decoder.sv
// Frame decoder for a byte stream of the form sync, type, 16-bit big-endian
// length, payload, CRC-8 (poly 0x07, init 0, MSB first), tail. The parser
// takes one byte per cycle while hunting, in the header and at the CRC and
// tail bytes. Payload bytes go into a MAX_PAYLOAD-byte store, so a payload
// byte is held off while a good frame is still read out of that store or a
// finished frame waits in the queue; the tail byte is held off while the
// two-entry frame queue is full. From the drain side a failed or zero-length
// frame loads its single item into the output register as it leaves the
// queue; a good frame gives one item per byte, fetched by the registered
// store read in a fetch state and loaded in an emit state. The output
// register lets the parser take bytes, within the store and queue limits,
// while a result waits on result_stall. The sync and tail values may be
// written through the configuration port while the block is idle.
module sync_length_crc8_frame_decoder
  import slcfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [7:0]              cfg_data,
  input  logic                    byte_valid,
  output logic                    byte_stall,
  input  logic [7:0]              rx_byte,
  output logic                    result_valid,
  input  logic                    result_stall,
  output logic [1:0]              status,
  output logic [7:0]              frame_type,
  output logic [15:0]             frame_len,
  output logic                    has_data,
  output logic [7:0]              data_byte,
  output logic [BYTE_INDEX_W-1:0] byte_index,
  output logic                    last
);

  logic    push;
  desc_t   push_data;
  logic    q_full;
  logic    pop;
  logic    head_valid;
  desc_t   head;
  mem_wr_t mem_wr;
  logic    back_idle;
  logic    store_free;

  // The store may take new payload only when no frame waits in the queue and none is being read out of it.
  assign store_free = back_idle && !head_valid;

  slcfd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .rx_byte    (rx_byte),
    .store_free (store_free),
    .q_full     (q_full),
    .push       (push),
    .push_data  (push_data),
    .mem_wr     (mem_wr)
  );

  slcfd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  slcfd_back u_back (
    .clk          (clk),
    .rst          (rst),
    .mem_wr       (mem_wr),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .idle         (back_idle),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .frame_type   (frame_type),
    .frame_len    (frame_len),
    .has_data     (has_data),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

endmodule

// File: tb/sync_length_crc8_frame_decoder_test.sv
module sync_length_crc8_frame_decoder_test;
  import slcfd_pkg::*;

  localparam int CYCLE_LIMIT   = 1500000;
  localparam int SETTLE_CYCLES = 8;
  localparam int BYTES_PER_SET = 12;

  // Payload fill modes; a value from 0 to 255 fills with that byte.
  localparam int FILL_RANDOM = -1;
  localparam int FILL_CLEAN  = -2;

  typedef enum {FLAW_NONE, FLAW_TAIL, FLAW_CRC, FLAW_CUT} flaw_t;

  // One decoded result item as the block should present it.
  typedef struct packed {
    status_t                 status;
    logic [7:0]              ftype;
    logic [15:0]             flen;
    logic                    has;
    logic [7:0]              data;
    logic [BYTE_INDEX_W-1:0] idx;
    logic                    last;
  } decoded_item_t;

  // One link byte waiting to be sent; drain_first holds it until all results are in.
  typedef struct packed {
    logic [7:0] value;
    logic       drain_first;
  } link_byte_t;

  logic                    clk          = 1'b0;
  logic                    rst          = 1'b1;
  logic                    cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index    = REG_SYNC;
  logic [7:0]              cfg_data     = 8'h00;
  logic                    byte_valid   = 1'b0;
  logic                    byte_stall;
  logic [7:0]              rx_byte      = 8'h00;
  logic                    result_valid;
  logic                    result_stall = 1'b0;
  logic [1:0]              status;
  logic [7:0]              frame_type;
  logic [15:0]             frame_len;
  logic                    has_data;
  logic [7:0]              data_byte;
  logic [BYTE_INDEX_W-1:0] byte_index;
  logic                    last;

  sync_length_crc8_frame_decoder i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .rx_byte      (rx_byte),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .frame_type   (frame_type),
    .frame_len    (frame_len),
    .has_data     (has_data),
    .data_byte    (data_byte),
    .byte_index   (byte_index),
    .last         (last)
  );

  always #1 clk = ~clk;

  // Register copies, shared by the decoder model and the frame builder.
  logic [7:0] cfg_sync = SYNC_RESET;
  logic [7:0] cfg_tail = TAIL_RESET;

  // Decoder model state.
  phase_t     dec_phase = PH_HUNT;
  logic [7:0] dec_type  = 8'h00;
  logic [15:0] dec_len  = 16'h0000;
  logic [15:0] dec_seen = 16'h0000;
  logic [7:0] dec_crc   = 8'h00;
  logic [7:0] dec_rx_crc = 8'h00;
  logic [7:0] dec_store [MAX_PAYLOAD];

  decoded_item_t decoded_items [$];
  link_byte_t    link_bytes [$];
  int            queued_bytes   = 0;
  bit            byte_in_flight = 1'b0;
  int            send_gap       = 0;
  int            stall_left     = 0;
  int            mismatches     = 0;
  int            cycle_count    = 0;
  bit            calm           = 1'b0;

  // CRC-8, polynomial 0x07, fed one bit at a time from the MSB.
  function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      r = {r[6:0], 1'b0} ^ ((r[7] ^ b[k]) ? 8'h07 : 8'h00);
    end
    return r;
  endfunction

  // Mostly short idle stretches, a few long ones, none while calm.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Advance the decoder model by one accepted byte and queue the items it yields.
  task automatic decode_byte(input logic [7:0] b);
    status_t       st;
    decoded_item_t it;
    case (dec_phase)
      PH_HUNT: begin
        if (b == cfg_sync) dec_phase = PH_TYPE;
      end
      PH_TYPE: begin
        dec_type  = b;
        dec_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        dec_len   = {b, 8'h00};
        dec_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        dec_len[7:0] = b;
        dec_seen     = 16'h0000;
        dec_crc      = 8'h00;
        dec_phase    = (dec_len == 16'h0000) ? PH_CRC : PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (dec_seen < MAX_PAYLOAD) dec_store[dec_seen[ADDR_W-1:0]] = b;
        dec_crc  = crc8_next(dec_crc, b);
        dec_seen = dec_seen + 16'd1;
        if (dec_seen >= dec_len) dec_phase = PH_CRC;
      end
      PH_CRC: begin
        dec_rx_crc = b;
        dec_phase  = PH_TAIL;
      end
      PH_TAIL: begin
        if (b != cfg_tail) st = ST_BAD_TAIL;
        else if (dec_crc != dec_rx_crc) st = ST_BAD_CRC;
        else if (dec_len > MAX_PAYLOAD) st = ST_TOO_LONG;
        else st = ST_GOOD;
        it.status = st;
        it.ftype  = dec_type;
        it.flen   = dec_len;
        it.has    = 1'b0;
        it.data   = 8'h00;
        it.idx    = '0;
        it.last   = 1'b1;
        if (st != ST_GOOD || dec_len == 16'h0000) begin
          decoded_items.push_back(it);
        end else begin
          for (int i = 0; i < dec_len && i < MAX_PAYLOAD; i++) begin
            it.has  = 1'b1;
            it.data = dec_store[i];
            it.idx  = i[BYTE_INDEX_W-1:0];
            it.last = (i + 1 == dec_len);
            decoded_items.push_back(it);
          end
        end
        dec_phase = PH_HUNT;
      end
      default: dec_phase = PH_HUNT;
    endcase
  endtask

  function automatic void push_link(input logic [7:0] v, input bit drain_first);
    link_byte_t e;
    e.value       = v;
    e.drain_first = drain_first;
    link_bytes.push_back(e);
    queued_bytes++;
  endfunction

  // Build one frame on the link; a cut frame stops somewhere in its payload.
  task automatic queue_frame(input logic [7:0] ftype, input int len, input flaw_t flaw,
                             input int fill, input bit drain_first);
    logic [7:0] payload [$];
    logic [7:0] frame_bytes [$];
    logic [7:0] b;
    logic [7:0] crc;
    logic [7:0] flip;
    int         keep;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom);
      if (fill >= 0) b = fill[7:0];
      else if (fill == FILL_CLEAN && b == cfg_sync) b = ~b;
      else if (fill == FILL_RANDOM && $urandom_range(0, 7) == 0) b = cfg_sync;
      payload.push_back(b);
    end
    // A clean payload also keeps its CRC byte off the sync value.
    do begin
      crc = 8'h00;
      foreach (payload[i]) crc = crc8_next(crc, payload[i]);
      if (fill == FILL_CLEAN && crc == cfg_sync) begin
        payload[0] = payload[0] + 8'd1;
        if (payload[0] == cfg_sync) payload[0] = payload[0] + 8'd1;
      end
    end while (fill == FILL_CLEAN && crc == cfg_sync);
    flip = 8'($urandom_range(1, 255));
    frame_bytes.push_back(cfg_sync);
    frame_bytes.push_back(ftype);
    frame_bytes.push_back(len[15:8]);
    frame_bytes.push_back(len[7:0]);
    foreach (payload[i]) frame_bytes.push_back(payload[i]);
    frame_bytes.push_back((flaw == FLAW_CRC) ? crc ^ flip : crc);
    frame_bytes.push_back((flaw == FLAW_TAIL) ? cfg_tail ^ flip : cfg_tail);
    keep = (flaw == FLAW_CUT) ? 4 + $urandom_range(0, len - 2) : frame_bytes.size();
    for (int i = 0; i < keep; i++) push_link(frame_bytes[i], drain_first && i == 0);
  endtask

  // A cut frame swallows the header and early payload of the next frame. The rest of that
  // frame carries no sync byte, so the decoder is hunting again once it has passed.
  task automatic queue_cut(input logic [7:0] ftype, input int len);
    queue_frame(ftype, len, FLAW_CUT, FILL_RANDOM, 1'b0);
    queue_frame(8'($urandom), 12, FLAW_NONE, FILL_CLEAN, 1'b0);
  endtask

  // Line noise that the hunting decoder drops.
  task automatic queue_noise(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      if (b == cfg_sync) b = ~b;
      push_link(b, 1'b0);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_SYNC) cfg_sync = val;
    else cfg_tail = val;
  endtask

  // Wait until every byte is taken and every result item is in, then let the block settle.
  task automatic wait_idle();
    do @(posedge clk);
    while (link_bytes.size() != 0 || byte_in_flight || decoded_items.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what);
    if (mismatches < 100) $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  // Byte driver: feeds the link from the pending queue with random gaps.
  always @(posedge clk) begin : drive
    logic       next_valid;
    logic [7:0] next_byte;
    link_byte_t head;
    if (rst) begin
      byte_valid     <= 1'b0;
      rx_byte        <= 8'h00;
      byte_in_flight = 1'b0;
    end else begin
      next_valid = byte_valid;
      next_byte  = rx_byte;
      if (byte_valid && !byte_stall) begin
        decode_byte(rx_byte);
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (link_bytes.size() != 0 &&
                     !(link_bytes[0].drain_first && decoded_items.size() != 0)) begin
          head       = link_bytes.pop_front();
          next_valid = 1'b1;
          next_byte  = head.value;
          send_gap   = pick_gap();
        end
      end
      byte_valid     <= next_valid;
      rx_byte        <= next_byte;
      byte_in_flight = next_valid;
    end
  end

  // Result monitor: checks each accepted item against the oldest prediction and drives random stalls.
  always @(posedge clk) begin : watch
    decoded_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (decoded_items.size() == 0) begin
          report_mismatch("result item with none expected");
        end else begin
          want = decoded_items.pop_front();
          check_field("status", 16'(status), 16'(want.status));
          check_field("frame_type", 16'(frame_type), 16'(want.ftype));
          check_field("frame_len", frame_len, want.flen);
          check_field("has_data", 16'(has_data), 16'(want.has));
          check_field("data_byte", 16'(data_byte), 16'(want.data));
          check_field("byte_index", 16'(byte_index), 16'(want.idx));
          check_field("last", 16'(last), 16'(want.last));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
        if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  // Cycle count, calm stretches and the run limit.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 400 == 0) calm <= ($urandom_range(0, 3) == 0);
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sync_length_crc8_frame_decoder] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0] sync_set [4];
    logic [7:0] tail_set [4];
    int         target;
    int         r;
    int         len;
    flaw_t      flaw;
    bit         paused;
    bit         pause_now;
    sync_set[0] = 8'h00;
    tail_set[0] = 8'hFF;
    sync_set[1] = 8'hFF;
    tail_set[1] = 8'h00;
    sync_set[2] = 8'h3C;
    tail_set[2] = 8'h3C;
    sync_set[3] = 8'($urandom);
    tail_set[3] = 8'($urandom);

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset register values.
    push_link(8'h00, 1'b0);
    push_link(8'hFF, 1'b0);
    push_link(cfg_tail, 1'b0);
    queue_frame(8'h00, 0, FLAW_NONE, FILL_RANDOM, 1'b0);
    queue_frame(8'hFF, 1, FLAW_NONE, 'hFF, 1'b0);
    queue_frame(8'h81, 3, FLAW_NONE, 'h00, 1'b0);
    queue_frame(cfg_sync, 2, FLAW_NONE, int'(cfg_sync), 1'b0);
    queue_frame(8'h3C, MAX_PAYLOAD, FLAW_NONE, FILL_RANDOM, 1'b0);
    queue_frame(8'h42, MAX_PAYLOAD + 1, FLAW_NONE, FILL_RANDOM, 1'b0);
    queue_frame(8'h11, 2, FLAW_TAIL, FILL_RANDOM, 1'b0);
    queue_frame(8'h22, 3, FLAW_CRC, FILL_RANDOM, 1'b1);
    queue_frame(8'h33, 0, FLAW_TAIL, FILL_RANDOM, 1'b0);
    queue_frame(8'h44, 0, FLAW_CRC, FILL_RANDOM, 1'b0);
    queue_frame(8'h55, 4, FLAW_CRC, int'(cfg_sync), 1'b0);
    queue_cut(8'h77, 5);
    queue_frame(8'h88, 1, FLAW_NONE, FILL_RANDOM, 1'b0);
    wait_idle();

    // Random traffic under several register settings.
    for (int s = 0; s < 4; s++) begin
      write_reg(REG_SYNC, sync_set[s]);
      write_reg(REG_TAIL, tail_set[s]);
      target = queued_bytes + BYTES_PER_SET;
      paused = 1'b0;
      while (queued_bytes < target) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          queue_noise($urandom_range(1, 4));
        end else if (r < 14 && cfg_sync != cfg_tail) begin
          queue_cut(8'($urandom), $urandom_range(2, 8));
        end else begin
          r = $urandom_range(0, 99);
          if (r < 80) len = $urandom_range(0, 8);
          else if (r < 95) len = $urandom_range(9, MAX_PAYLOAD - 1);
          else len = $urandom_range(MAX_PAYLOAD, MAX_PAYLOAD + 6);
          r = $urandom_range(0, 99);
          flaw = (r < 70) ? FLAW_NONE : (r < 85) ? FLAW_TAIL : FLAW_CRC;
          pause_now = !paused && queued_bytes >= target - BYTES_PER_SET / 2;
          if (pause_now) paused = 1'b1;
          queue_frame(8'($urandom), len, flaw, FILL_RANDOM, pause_now);
        end
      end
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("[sync_length_crc8_frame_decoder] OK");
    end else begin
      $display("[sync_length_crc8_frame_decoder] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/slcfd_pkg.sv
rtl/slcfd_queue.sv
rtl/slcfd_front.sv
rtl/slcfd_back.sv
rtl/sync_length_crc8_frame_decoder.sv
tb/sync_length_crc8_frame_decoder_test.sv
